@@ sv/bhm_pkg.sv @@
// shared types and codes for the bucketed hash map
package bhm_pkg;

  localparam int KeyW  = 31;
  localparam int DataW = 31;

  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_ABSENT = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
  } rsp_t;

endpackage

@@ sv/bucketed_hash_map.sv @@
// Bucketed key/value table: one put, get or remove per input word, one response word each.
// A command is taken only while the block is idle. Its bucket (key mod BUCKETS) comes from a
// remainder unit that answers in the cycle after the command when BUCKETS is a power of two
// and otherwise once its steps are done (reciprocal multiply, back-multiply and subtract, one
// correction). The way memory is then read and compared one way at a time until a hit or the
// last way, and a final state writes back and loads the response register, which waits while
// the previous response is still held. After reset the valid rows are cleared one bucket per
// cycle, and no command is taken until every bucket is cleared.
module bucketed_hash_map #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bhm_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bhm_pkg::rsp_t out_data_o
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SW = (BUCKETS * WAYS > 1) ? $clog2(BUCKETS * WAYS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int KW = bhm_pkg::KeyW;
  localparam int DW = bhm_pkg::DataW;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_MOD, S_RD, S_CMP, S_ACT
  } state_e;

  state_e        state_q;
  logic [BW-1:0] clr_q;
  logic [1:0]    cmd_q;
  logic [KW-1:0] key_q;
  logic [DW-1:0] value_q;
  logic [SW-1:0] base_q;
  logic [BW-1:0] bucket_q;
  logic [WW-1:0] way_q;
  logic          hit_q;
  logic [WW-1:0] hit_way_q;
  logic [DW-1:0] hit_data_q;
  logic          out_valid_q;
  bhm_pkg::rsp_t out_q;

  logic          in_fire;
  logic          mod_done;
  logic [BW-1:0] mod_rem;
  logic [WAYS-1:0] row;
  logic [KW+DW-1:0] ent;
  logic          act_go;
  logic          free_found;
  logic [WW-1:0] free_way;
  logic          row_we, ent_we;
  logic [BW-1:0] row_waddr;
  logic [WAYS-1:0] row_wdata;
  logic [SW-1:0] ent_waddr;
  logic          ent_match;
  bhm_pkg::rsp_t rsp;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign act_go     = (state_q == S_ACT) && (!out_valid_q || out_ready_i);
  assign ent_match  = row[way_q] && (ent[KW+DW-1:DW] == key_q);

  bhm_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .key_i   (in_data_i.key),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  bhm_store #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_store (
    .clk_i       (clk_i),
    .row_re_i    ((state_q == S_MOD) && mod_done),
    .row_raddr_i (mod_rem),
    .row_rdata_o (row),
    .row_we_i    (row_we),
    .row_waddr_i (row_waddr),
    .row_wdata_i (row_wdata),
    .ent_re_i    (state_q == S_RD),
    .ent_raddr_i (base_q + SW'(way_q)),
    .ent_rdata_o (ent),
    .ent_we_i    (ent_we),
    .ent_waddr_i (ent_waddr),
    .ent_wdata_i ({key_q, value_q})
  );

  // lowest free way of the bucket
  always_comb begin
    free_found = 1'b0;
    free_way   = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!row[i]) begin
        free_found = 1'b1;
        free_way   = WW'(i);
      end
    end
  end

  // row clear after reset, else write-back and response of the finished command
  always_comb begin
    row_we         = 1'b0;
    row_waddr      = bucket_q;
    row_wdata      = row;
    ent_we         = 1'b0;
    ent_waddr      = base_q + SW'(hit_way_q);
    rsp.status     = bhm_pkg::STATUS_OK;
    rsp.read_value = '1;
    if (state_q == S_CLR) begin
      row_we    = 1'b1;
      row_waddr = clr_q;
      row_wdata = '0;
    end else begin
      case (cmd_q)
        bhm_pkg::CMD_PUT: begin
          if (hit_q) begin
            ent_we = act_go;
          end else if (free_found) begin
            ent_we    = act_go;
            ent_waddr = base_q + SW'(free_way);
            row_we    = act_go;
            row_wdata = row | (WAYS'(1) << free_way);
          end else begin
            rsp.status = bhm_pkg::STATUS_FULL;
          end
        end
        bhm_pkg::CMD_GET: begin
          if (hit_q) begin
            rsp.read_value = {1'b0, hit_data_q};
          end else begin
            rsp.status = bhm_pkg::STATUS_ABSENT;
          end
        end
        bhm_pkg::CMD_REMOVE: begin
          if (hit_q) begin
            row_we    = act_go;
            row_wdata = row & ~(WAYS'(1) << hit_way_q);
          end else begin
            rsp.status = bhm_pkg::STATUS_ABSENT;
          end
        end
        default: begin
          rsp.status = bhm_pkg::STATUS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      way_q       <= '0;
      hit_q       <= 1'b0;
    end else begin
      if (act_go) begin
        out_valid_q <= 1'b1;
        out_q       <= rsp;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == BW'(BUCKETS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            cmd_q   <= in_data_i.cmd;
            key_q   <= in_data_i.key;
            value_q <= in_data_i.value;
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            bucket_q <= mod_rem;
            base_q   <= SW'(mod_rem) * SW'(WAYS);
            way_q    <= '0;
            hit_q    <= 1'b0;
            state_q  <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (ent_match) begin
            hit_q      <= 1'b1;
            hit_way_q  <= way_q;
            hit_data_q <= ent[DW-1:0];
            state_q    <= S_ACT;
          end else if (way_q == WW'(WAYS - 1)) begin
            state_q <= S_ACT;
          end else begin
            way_q   <= way_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_ACT: begin
          if (act_go) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/bhm_mod.sv @@
// bucket index unit: key modulo the bucket count by reciprocal multiply and one correction
module bhm_mod #(
  parameter int BUCKETS = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [bhm_pkg::KeyW-1:0]               key_i,
  output logic                                   done_o,
  output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] rem_o
);

  localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RW   = BW + 1;
  localparam int KW   = bhm_pkg::KeyW;
  localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  // floor(2^31 / BUCKETS): the estimated quotient is low by at most one
  localparam logic [31:0] RECIP = 32'(64'h8000_0000 / 64'(BUCKETS));

  typedef enum logic [1:0] {
    M_IDLE, M_MUL, M_SUB, M_FIX
  } mstate_e;

  mstate_e       mstate_q;
  logic          done_q;
  logic [BW-1:0] rem_q;
  logic [KW-1:0] key_q;
  logic [31:0]   quo_q;
  logic [RW-1:0] part_q;
  logic [62:0]   prod;
  logic [31:0]   diff;
  logic [RW-1:0] fix;

  // partial remainder is below twice the bucket count, so one subtract finishes it
  always_comb begin
    prod = 63'(key_q) * 63'(RECIP);
    diff = 32'(key_q) - quo_q * 32'(BUCKETS);
    fix  = part_q;
    if (part_q >= RW'(BUCKETS)) begin
      fix = part_q - RW'(BUCKETS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      mstate_q <= M_IDLE;
    end else begin
      if (POW2) begin
        done_q <= start_i;
        if (start_i) begin
          rem_q <= (BUCKETS == 1) ? '0 : BW'(key_i);
        end
      end else begin
        done_q <= (mstate_q == M_FIX);
        unique case (mstate_q)
          M_IDLE: begin
            if (start_i) begin
              key_q    <= key_i;
              mstate_q <= M_MUL;
            end
          end
          M_MUL: begin
            quo_q    <= prod[62:31];
            mstate_q <= M_SUB;
          end
          M_SUB: begin
            part_q   <= diff[RW-1:0];
            mstate_q <= M_FIX;
          end
          M_FIX: begin
            rem_q    <= fix[BW-1:0];
            mstate_q <= M_IDLE;
          end
          default: begin
            mstate_q <= M_IDLE;
          end
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ sv/bhm_store.sv @@
// table storage: valid row per bucket and key/data word per way
module bhm_store #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4
) (
  input  logic                     clk_i,
  input  logic                     row_re_i,
  input  logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] row_raddr_i,
  output logic [WAYS-1:0]          row_rdata_o,
  input  logic                     row_we_i,
  input  logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] row_waddr_i,
  input  logic [WAYS-1:0]          row_wdata_i,
  input  logic                     ent_re_i,
  input  logic [(BUCKETS * WAYS > 1 ? $clog2(BUCKETS * WAYS) : 1)-1:0] ent_raddr_i,
  output logic [bhm_pkg::KeyW+bhm_pkg::DataW-1:0] ent_rdata_o,
  input  logic                     ent_we_i,
  input  logic [(BUCKETS * WAYS > 1 ? $clog2(BUCKETS * WAYS) : 1)-1:0] ent_waddr_i,
  input  logic [bhm_pkg::KeyW+bhm_pkg::DataW-1:0] ent_wdata_i
);

  localparam int SLOTS = BUCKETS * WAYS;
  localparam int EW    = bhm_pkg::KeyW + bhm_pkg::DataW;

  logic [WAYS-1:0] row_mem [BUCKETS];
  logic [EW-1:0]   ent_mem [SLOTS];
  logic [WAYS-1:0] row_rdata_q;
  logic [EW-1:0]   ent_rdata_q;

  always_ff @(posedge clk_i) begin
    if (row_we_i) begin
      row_mem[row_waddr_i] <= row_wdata_i;
    end
    if (row_re_i) begin
      row_rdata_q <= row_mem[row_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we_i) begin
      ent_mem[ent_waddr_i] <= ent_wdata_i;
    end
    if (ent_re_i) begin
      ent_rdata_q <= ent_mem[ent_raddr_i];
    end
  end

  assign row_rdata_o = row_rdata_q;
  assign ent_rdata_o = ent_rdata_q;

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the bucketed hash map: directed table, then random commands
module testbench;

  localparam int Buckets = 1024;
  localparam int Ways = 4;
  localparam int Slots = Buckets * Ways;
  localparam int RandomPerPhase = 550;
  localparam int PoolSize = 32;
  localparam int HotBuckets = 6;
  localparam int CycleLimit = 600000;
  // worst command: remainder, read and compare of every way, write back, idle, plus some slack
  localparam int TailCycles = 2 + 2 * Ways + 4 + 16;
  localparam int ReportLimit = 10;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam logic [bhm_pkg::KeyW-1:0] KeyMax = '1;
  localparam logic [bhm_pkg::DataW-1:0] DataMax = '1;
  localparam logic signed [31:0] NotFound = -1;

  typedef struct {
    logic [1:0]                  cmd;
    logic [bhm_pkg::KeyW-1:0]    key;
    logic [bhm_pkg::DataW-1:0]   value;
    bit                          typed;
    logic [1:0]                  status;
    logic signed [31:0]          rv;
  } dir_row_t;

  localparam int NumDir = 24;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bhm_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bhm_pkg::rsp_t out_data;

  // expectation that goes with the word on the input port
  bit   cur_typed = 1'b0;
  bhm_pkg::rsp_t cur_rsp = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  bhm_pkg::rsp_t pending_rsp[$];

  // shadow of the table
  bit                        slot_valid[Slots];
  logic [bhm_pkg::KeyW-1:0]  slot_key[Slots];
  logic [bhm_pkg::DataW-1:0] slot_data[Slots];

  logic [bhm_pkg::KeyW-1:0] key_pool[PoolSize];
  int unsigned              hot[HotBuckets];

  dir_row_t dir_rows[NumDir] = '{
    '{bhm_pkg::CMD_GET,    '0,           '0,           1'b1, bhm_pkg::STATUS_ABSENT, NotFound},
    '{bhm_pkg::CMD_REMOVE, KeyMax,       '0,           1'b1, bhm_pkg::STATUS_ABSENT, NotFound},
    '{bhm_pkg::CMD_PUT,    '0,           '0,           1'b1, bhm_pkg::STATUS_OK,     NotFound},
    '{bhm_pkg::CMD_GET,    '0,           '0,           1'b1, bhm_pkg::STATUS_OK,     32'sd0},
    '{bhm_pkg::CMD_PUT,    KeyMax,       DataMax,      1'b1, bhm_pkg::STATUS_OK,     NotFound},
    '{bhm_pkg::CMD_GET,    KeyMax,       '0,           1'b1, bhm_pkg::STATUS_OK,
      32'sh7fffffff},
    '{bhm_pkg::CMD_PUT,    '0,           31'h2aaaaaaa, 1'b0, bhm_pkg::STATUS_OK,     NotFound},
    '{bhm_pkg::CMD_GET,    '0,           '0,           1'b0, bhm_pkg::STATUS_OK,     NotFound},
    '{bhm_pkg::CMD_PUT,    31'd1024,     31'h55555555, 1'b0, bhm_pkg::STATUS_OK,     NotFound},
    '{bhm_pkg::CMD_PUT,    31'd2048,     31'd1,        1'b0, bhm_pkg::STATUS_OK,     NotFound},
    '{bhm_pkg::CMD_PUT,    31'd3072,     DataMax,      1'b0, bhm_pkg::STATUS_OK,     NotFound},
    '{bhm_pkg::CMD_PUT,    31'd4096,     31'd7,        1'b1, bhm_pkg::STATUS_FULL,   NotFound},
    '{bhm_pkg::CMD_GET,    31'd4096,     '0,           1'b1, bhm_pkg::STATUS_ABSENT, NotFound},
    '{bhm_pkg::CMD_REMOVE, 31'd2048,     '0,           1'b1, bhm_pkg::STATUS_OK,     NotFound},
    '{bhm_pkg::CMD_PUT,    31'd4096,     31'h12345678, 1'b0, bhm_pkg::STATUS_OK,     NotFound},
    '{bhm_pkg::CMD_GET,    31'd4096,     '0,           1'b0, bhm_pkg::STATUS_OK,     NotFound},
    '{bhm_pkg::CMD_GET,    31'd3072,     '0,           1'b0, bhm_pkg::STATUS_OK,     NotFound},
    '{bhm_pkg::CMD_REMOVE, 31'd2048,     '0,           1'b1, bhm_pkg::STATUS_ABSENT, NotFound},
    '{CmdUnused,           '0,           DataMax,      1'b1, bhm_pkg::STATUS_OK,     NotFound},
    '{bhm_pkg::CMD_GET,    '0,           '0,           1'b0, bhm_pkg::STATUS_OK,     NotFound},
    '{bhm_pkg::CMD_REMOVE, KeyMax,       '0,           1'b1, bhm_pkg::STATUS_OK,     NotFound},
    '{bhm_pkg::CMD_GET,    KeyMax,       '0,           1'b1, bhm_pkg::STATUS_ABSENT, NotFound},
    '{bhm_pkg::CMD_PUT,    31'h7ffffc00, DataMax,      1'b1, bhm_pkg::STATUS_FULL,   NotFound},
    '{bhm_pkg::CMD_GET,    31'd1024,     '0,           1'b0, bhm_pkg::STATUS_OK,     NotFound}
  };

  bucketed_hash_map #(
    .BUCKETS(Buckets),
    .WAYS   (Ways)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // apply one command to the shadow table and return its response word
  function automatic bhm_pkg::rsp_t map_apply(bhm_pkg::req_t w);
    bhm_pkg::rsp_t r;
    int base;
    int hit;
    r.status = bhm_pkg::STATUS_OK;
    r.read_value = NotFound;
    base = int'(w.key % Buckets) * Ways;
    hit = -1;
    for (int i = 0; i < Ways; i++) begin
      if (hit < 0 && slot_valid[base + i] && slot_key[base + i] == w.key) hit = base + i;
    end
    case (w.cmd)
      bhm_pkg::CMD_PUT: begin
        if (hit >= 0) begin
          slot_data[hit] = w.value;
        end else begin
          r.status = bhm_pkg::STATUS_FULL;
          // lowest free way takes the new pair
          for (int i = 0; i < Ways; i++) begin
            if (r.status == bhm_pkg::STATUS_FULL && !slot_valid[base + i]) begin
              slot_valid[base + i] = 1'b1;
              slot_key[base + i] = w.key;
              slot_data[base + i] = w.value;
              r.status = bhm_pkg::STATUS_OK;
            end
          end
        end
      end
      bhm_pkg::CMD_GET: begin
        if (hit >= 0) r.read_value = {1'b0, slot_data[hit]};
        else r.status = bhm_pkg::STATUS_ABSENT;
      end
      bhm_pkg::CMD_REMOVE: begin
        if (hit >= 0) slot_valid[hit] = 1'b0;
        else r.status = bhm_pkg::STATUS_ABSENT;
      end
      default: ;
    endcase
    return r;
  endfunction

  // mostly keys from a few crowded buckets so hits, updates and full buckets happen often
  function automatic bhm_pkg::req_t random_word();
    bhm_pkg::req_t w;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) w.cmd = bhm_pkg::CMD_PUT;
    else if (pick < 75) w.cmd = bhm_pkg::CMD_GET;
    else if (pick < 97) w.cmd = bhm_pkg::CMD_REMOVE;
    else w.cmd = CmdUnused;
    if ($urandom_range(99) < 85) w.key = key_pool[$urandom_range(PoolSize - 1)];
    else w.key = bhm_pkg::KeyW'($urandom);
    case ($urandom_range(9))
      0: w.value = '0;
      1: w.value = DataMax;
      default: w.value = bhm_pkg::DataW'($urandom);
    endcase
    return w;
  endfunction

  task automatic report(string what, bhm_pkg::rsp_t want);
    mismatches++;
    if (mismatches <= ReportLimit) begin
      $display("%s: expected status %0d value %0d, got status %0d value %0d", what,
               want.status, want.read_value, out_data.status, out_data.read_value);
    end
  endtask

  task automatic send_word(bhm_pkg::req_t w, bit typed, bhm_pkg::rsp_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data = w;
    cur_typed = typed;
    cur_rsp = want;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_n) out_ready = ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    bhm_pkg::rsp_t want;
    if (rst_n && in_valid && in_ready) begin
      want = map_apply(in_data);
      if (cur_typed) want = cur_rsp;
      pending_rsp.push_back(want);
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        report("unexpected word", '0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data.status !== want.status) report("status mismatch", want);
        else if (out_data.read_value !== want.read_value) report("read_value mismatch", want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("** bucketed_hash_map: FAILED **");
      $finish;
    end
  end

  initial begin
    bhm_pkg::rsp_t want;
    foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 7;
          rx_idle_pct = 87;
        end
        1: begin
          tx_idle_pct = 87;
          rx_idle_pct = 7;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase

      // new crowded buckets each phase, always including both ends of the bucket range
      hot[0] = 0;
      hot[1] = Buckets - 1;
      for (int i = 2; i < HotBuckets; i++) hot[i] = $urandom_range(Buckets - 1);
      for (int i = 0; i < PoolSize; i++) begin
        key_pool[i] = bhm_pkg::KeyW'($urandom_range(2097151) * Buckets + hot[i % HotBuckets]);
      end

      if (phase == 0) begin
        foreach (dir_rows[i]) begin
          want.status = dir_rows[i].status;
          want.read_value = dir_rows[i].rv;
          send_word('{cmd: dir_rows[i].cmd, key: dir_rows[i].key, value: dir_rows[i].value},
                    dir_rows[i].typed, want);
        end
      end
      repeat (RandomPerPhase) send_word(random_word(), 1'b0, '0);
    end
    in_valid = 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("** bucketed_hash_map: PASSED **");
    end else begin
      $display("** bucketed_hash_map: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/bhm_pkg.sv
sv/bhm_mod.sv
sv/bhm_store.sv
sv/bucketed_hash_map.sv
tb/testbench.sv
